// ===== hw/rtl/ins_sort_pkg.sv =====
// Shared types for the insertion sorter.
// Holds the per-cell control and link structs; no dependencies.
package ins_sort_pkg;

    localparam int unsigned DATA_W = 32;

    // Control broadcast to every cell of the row
    typedef struct packed {
        logic insert;   // place the broadcast value into the sorted row
        logic shift;    // move every entry down one place toward the output
    } t_cell_ctrl;

    // What a cell shows its upper neighbor
    typedef struct packed {
        logic                     valid;  // cell holds a list entry
        logic                     gt;     // entry is strictly greater than the new value
        logic signed [DATA_W-1:0] value;  // stored entry
    } t_cell_link;

endpackage

// ===== hw/rtl/ins_sort_cell.sv =====
// One cell of the insertion row: a single stored entry and its compare.
// Depends on ins_sort_pkg for the link and control structs.
module ins_sort_cell (
    input  logic                                   i_clk,
    input  ins_sort_pkg::t_cell_ctrl               i_ctrl,
    input  logic signed [ins_sort_pkg::DATA_W-1:0] i_value,
    input  logic                                   i_self_valid,
    input  ins_sort_pkg::t_cell_link               i_prev,
    input  logic signed [ins_sort_pkg::DATA_W-1:0] i_next_value,
    output ins_sort_pkg::t_cell_link               o_link
);

    logic signed [ins_sort_pkg::DATA_W-1:0] r_value;
    logic signed [ins_sort_pkg::DATA_W-1:0] n_value;
    logic                                   w_gt;

    // Compare the stored entry against the broadcast value
    assign w_gt = i_self_valid && (r_value > i_value);

    // Shift out, take the lower neighbor's entry, take the new value, or hold
    always_comb begin
        n_value = r_value;
        if (i_ctrl.shift) begin
            n_value = i_next_value;
        end else if (i_ctrl.insert) begin
            if (i_prev.gt) begin
                n_value = i_prev.value;
            end else if ((w_gt || !i_self_valid) && i_prev.valid) begin
                n_value = i_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_link.valid = i_self_valid;
    assign o_link.gt    = w_gt;
    assign o_link.value = r_value;

endmodule

// ===== hw/rtl/insertion_sorter_top.sv =====
// Top level of the insertion sorter: a row of sort cells plus count and drain control.
// Depends on ins_sort_pkg and ins_sort_cell.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  input   | start, busy          | i_value, i_last_item
//  result  | o_valid (strobe)     | o_sorted_value, o_last_result, o_dropped
//
// Each non-last transaction is taken whenever busy is low; the whole row inserts in parallel.
// A last transaction is inserted unless the row is full, then the row shifts out one entry per cycle:
// busy stays high until every stored entry (1..MAX_ITEMS of them) has been shown.
// Reset (synchronous, active low) empties the row and clears the dropped flag.
// The receiver cannot stall; every result is shown for exactly one cycle.
module insertion_sorter_top #(
    parameter int unsigned MAX_ITEMS = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [ins_sort_pkg::DATA_W-1:0] i_value,
    input  logic                                   i_last_item,
    output logic                                   o_valid,
    output logic signed [ins_sort_pkg::DATA_W-1:0] o_sorted_value,
    output logic                                   o_last_result,
    output logic                                   o_dropped
);

    localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_drain;
    logic                     n_drain;
    logic                     r_overflow;
    logic                     n_overflow;
    logic                     w_accept;
    logic                     w_full;
    ins_sort_pkg::t_cell_ctrl w_ctrl;
    ins_sort_pkg::t_cell_link w_link [MAX_ITEMS];

    assign w_accept = start && !busy;
    assign w_full   = (r_count == CNT_W'(MAX_ITEMS));

    assign w_ctrl.insert = w_accept && !w_full;
    assign w_ctrl.shift  = r_drain;

    // Build the row of cells
    for (genvar gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
        ins_sort_pkg::t_cell_link               w_prev;
        logic signed [ins_sort_pkg::DATA_W-1:0] w_next_value;

        if (gi == 0) begin : g_first
            assign w_prev.valid = 1'b1;
            assign w_prev.gt    = 1'b0;
            assign w_prev.value = '0;
        end else begin : g_inner
            assign w_prev = w_link[gi-1];
        end

        if (gi == MAX_ITEMS - 1) begin : g_top
            assign w_next_value = '0;
        end else begin : g_below
            assign w_next_value = w_link[gi+1].value;
        end

        ins_sort_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_value      (i_value),
            .i_self_valid (r_count > CNT_W'(gi)),
            .i_prev       (w_prev),
            .i_next_value (w_next_value),
            .o_link       (w_link[gi])
        );
    end

    // Advance count, drain and overflow state
    always_comb begin
        n_count    = r_count;
        n_drain    = r_drain;
        n_overflow = r_overflow;
        if (r_drain) begin
            n_count = r_count - CNT_W'(1);
            if (r_count == CNT_W'(1)) begin
                n_drain    = 1'b0;
                n_overflow = 1'b0;
            end
        end else if (w_accept) begin
            if (w_full) begin
                n_overflow = 1'b1;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
            n_drain = i_last_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_drain    <= 1'b0;
            r_overflow <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_drain    <= n_drain;
            r_overflow <= n_overflow;
        end
    end

    // Drive the result strobe from the drain flag and the value from the bottom cell
    assign busy           = r_drain;
    assign o_valid        = r_drain;
    assign o_sorted_value = w_link[0].value;
    assign o_last_result  = r_drain && (r_count == CNT_W'(1));
    assign o_dropped      = r_overflow;

`ifndef SYNTHESIS
    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain |-> (r_count != '0))
        else $error("drain with empty row");

    a_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_result) |=> (r_count == '0 && !r_overflow && !busy))
        else $error("row not emptied after final result");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_result) |=> o_valid)
        else $error("result run broken off early");

    a_insert_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_full) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the row");

    a_full_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_full) |=> r_overflow)
        else $error("drop not flagged");
`endif

endmodule
